[src/ptmg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ptmg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_LINES = 2048;

	localparam logic [23:0] ONE_FX      = 24'(1) << FRAC_BITS;
	localparam logic [15:0] GAMMA_UNITY = 16'd4096;
	localparam logic [15:0] GAMMA_MIN   = 16'd1024;
	localparam logic [14:0] EXP_CORR    = 15'd22489;
	localparam logic [11:0] VLINES_RST  = 12'd480;
	localparam logic [11:0] VLINES_MAX  = 12'(MAX_LINES);

	localparam logic [1:0] REG_SHOW_OOG = 2'd0;
	localparam logic [1:0] REG_GAMMA    = 2'd1;
	localparam logic [1:0] REG_VLINES   = 2'd2;

	typedef struct packed {
		logic [10:0] row;
		logic [10:0] column;
		logic [23:0] red_raw;
		logic [23:0] green_raw;
		logic [23:0] blue_raw;
	} pix_in_t;

	typedef struct packed {
		logic [10:0] screen_x;
		logic [10:0] screen_y;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
	} pix_out_t;

endpackage

`default_nettype wire

[src/pixel_tone_map_gamma_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one pixel per clock; busy stays low and the receiver cannot stall.
// Depth is set by the 17-step tone-map divider, the 16-step log2 squaring chain
// and the 23-step gamma divider, one step per stage, three channel lanes each.
// Reset clears the valid pipeline and loads the registers with 0, 4096 and 480.
module pixel_tone_map_gamma_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ptmg_pkg::pix_in_t   pixel,
	output logic                done,
	output ptmg_pkg::pix_out_t  result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int TD_N = 17;
	localparam int LG_N = 16;
	localparam int ED_N = 23;
	localparam int LAT  = 63;
	localparam int CRD_N = LAT - 1;
	localparam int XV_N  = 43;

	function automatic logic [3:0] lead_pos(input logic [15:0] v);
		logic [3:0] p;
		p = '0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) begin
				p = 4'(i);
			end
		end
		return p;
	endfunction

	// configuration
	logic        show_oog_q;
	logic [15:0] gamma_q;
	logic [11:0] vlines_q;
	logic [15:0] g_eff;
	logic        gbyp;
	logic [11:0] vl_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_oog_q <= 1'b0;
			gamma_q    <= ptmg_pkg::GAMMA_UNITY;
			vlines_q   <= ptmg_pkg::VLINES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ptmg_pkg::REG_SHOW_OOG: show_oog_q <= cfg_data[0];
				ptmg_pkg::REG_GAMMA:    gamma_q    <= cfg_data;
				ptmg_pkg::REG_VLINES:   vlines_q   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign g_eff  = (gamma_q < ptmg_pkg::GAMMA_MIN) ? ptmg_pkg::GAMMA_MIN : gamma_q;
	assign gbyp   = (gamma_q == ptmg_pkg::GAMMA_UNITY);
	assign vl_eff = (vlines_q > ptmg_pkg::VLINES_MAX) ? ptmg_pkg::VLINES_MAX : vlines_q;

	// valid bits and coordinates
	logic            accept;
	logic [LAT-1:0]  vld_s;
	logic [21:0]     crd_s [CRD_N];
	logic [10:0]     sy_in;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign done   = vld_s[LAT-1];
	assign sy_in  = 11'(vl_eff - 12'd1 - {1'b0, pixel.row});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		crd_s[0] <= {pixel.column, sy_in};
		for (int i = 1; i < CRD_N; i++) begin
			crd_s[i] <= crd_s[i-1];
		end
	end

	// entry: largest channel and tone-map decision
	logic [23:0] ch_in [3];
	logic [23:0] mx_in;
	logic        over_in;
	logic [23:0] a_ch_s1 [3];
	logic [23:0] a_mx_s1;
	logic        a_scale_s1;
	logic [16:0] a_pass_s1 [3];

	assign ch_in[0] = pixel.red_raw;
	assign ch_in[1] = pixel.green_raw;
	assign ch_in[2] = pixel.blue_raw;

	always_comb begin
		mx_in = ch_in[0];
		if (ch_in[1] > mx_in) begin
			mx_in = ch_in[1];
		end
		if (ch_in[2] > mx_in) begin
			mx_in = ch_in[2];
		end
		over_in = mx_in > ptmg_pkg::ONE_FX;
	end

	always_ff @(posedge clk) begin
		a_mx_s1    <= mx_in;
		a_scale_s1 <= over_in & ~show_oog_q;
		for (int c = 0; c < 3; c++) begin
			a_ch_s1[c] <= ch_in[c];
			if (over_in && show_oog_q) begin
				a_pass_s1[c] <= (c == 0) ? ptmg_pkg::ONE_FX[16:0] : 17'd0;
			end else begin
				a_pass_s1[c] <= ch_in[c][16:0];
			end
		end
	end

	// tone-map divider: floor(c * ONE / max), one quotient bit per stage
	logic [23:0] td_r_s    [TD_N][3];
	logic [16:0] td_q_s    [TD_N][3];
	logic [23:0] td_mx_s   [TD_N];
	logic        td_scale_s [TD_N];
	logic [16:0] td_pass_s [TD_N][3];

	genvar k, c, j;
	for (k = 0; k < TD_N; k++) begin : g_td
		logic [23:0] den;
		logic        scl;
		logic [16:0] pas [3];
		if (k == 0) begin : g_first
			assign den = a_mx_s1;
			assign scl = a_scale_s1;
			assign pas = a_pass_s1;
		end else begin : g_next
			assign den = td_mx_s[k-1];
			assign scl = td_scale_s[k-1];
			assign pas = td_pass_s[k-1];
		end
		always_ff @(posedge clk) begin
			td_mx_s[k]    <= den;
			td_scale_s[k] <= scl;
			td_pass_s[k]  <= pas;
		end
		for (c = 0; c < 3; c++) begin : g_ch
			logic [24:0] num;
			logic [16:0] qp;
			logic        ge;
			if (k == 0) begin : g_first
				assign num = {1'b0, a_ch_s1[c]};
				assign qp  = '0;
			end else begin : g_next
				assign num = {td_r_s[k-1][c], 1'b0};
				assign qp  = td_q_s[k-1][c];
			end
			assign ge = num >= {1'b0, den};
			always_ff @(posedge clk) begin
				td_r_s[k][c] <= ge ? 24'(num - {1'b0, den}) : num[23:0];
				td_q_s[k][c] <= {qp[15:0], ge};
			end
		end
	end

	// log2 setup: pick channel value, normalize mantissa to 1.30
	logic [16:0] x_sel [3];
	logic [3:0]  p_sel [3];
	logic [16:0] xv_s [XV_N][3];
	logic [30:0] lx_m_s [3];
	logic [3:0]  lx_p_s [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			x_sel[i] = td_scale_s[TD_N-1] ? td_q_s[TD_N-1][i] : td_pass_s[TD_N-1][i];
			p_sel[i] = lead_pos(x_sel[i][15:0]);
		end
	end

	always_ff @(posedge clk) begin
		xv_s[0] <= x_sel;
		for (int i = 1; i < XV_N; i++) begin
			xv_s[i] <= xv_s[i-1];
		end
		for (int i = 0; i < 3; i++) begin
			lx_m_s[i] <= 31'(x_sel[i][15:0]) << (5'd30 - {1'b0, p_sel[i]});
			lx_p_s[i] <= p_sel[i];
		end
	end

	// log2 fraction: square the mantissa, one bit per stage
	logic [30:0] lg_m_s [LG_N][3];
	logic [15:0] lg_f_s [LG_N][3];
	logic [3:0]  lg_p_s [LG_N][3];

	for (j = 0; j < LG_N; j++) begin : g_lg
		for (c = 0; c < 3; c++) begin : g_ch
			logic [30:0] mp;
			logic [15:0] fp;
			logic [3:0]  pp;
			logic [61:0] sq;
			logic [31:0] mm;
			if (j == 0) begin : g_first
				assign mp = lx_m_s[c];
				assign fp = '0;
				assign pp = lx_p_s[c];
			end else begin : g_next
				assign mp = lg_m_s[j-1][c];
				assign fp = lg_f_s[j-1][c];
				assign pp = lg_p_s[j-1][c];
			end
			assign sq = 62'(mp) * 62'(mp);
			assign mm = sq[61:30];
			always_ff @(posedge clk) begin
				lg_m_s[j][c] <= mm[31] ? mm[31:1] : mm[30:0];
				lg_f_s[j][c] <= {fp[14:0], mm[31]};
				lg_p_s[j][c] <= pp;
			end
		end
	end

	// L = -log2(x) in Q16
	logic [20:0] ll_l_s [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ll_l_s[i] <= {5'(5'd16 - {1'b0, lg_p_s[LG_N-1][i]}), 16'd0}
				- {5'd0, lg_f_s[LG_N-1][i]};
		end
	end

	// gamma divider: e = floor(L * 4096 / g), one quotient bit per stage
	logic [15:0] ed_r_s [ED_N][3];
	logic [10:0] ed_l_s [ED_N][3];
	logic [22:0] ed_q_s [ED_N][3];

	for (j = 0; j < ED_N; j++) begin : g_ed
		for (c = 0; c < 3; c++) begin : g_ch
			logic [15:0] rp;
			logic [10:0] lp;
			logic [22:0] qp;
			logic        bin;
			logic [16:0] num;
			logic        ge;
			if (j == 0) begin : g_first
				assign rp = {6'd0, ll_l_s[c][20:11]};
				assign lp = ll_l_s[c][10:0];
				assign qp = '0;
			end else begin : g_next
				assign rp = ed_r_s[j-1][c];
				assign lp = ed_l_s[j-1][c];
				assign qp = ed_q_s[j-1][c];
			end
			if (j <= 10) begin : g_lbit
				assign bin = lp[10-j];
			end else begin : g_zbit
				assign bin = 1'b0;
			end
			assign num = {rp, bin};
			assign ge  = num >= {1'b0, g_eff};
			always_ff @(posedge clk) begin
				ed_r_s[j][c] <= ge ? 16'(num - {1'b0, g_eff}) : num[15:0];
				ed_l_s[j][c] <= lp;
				ed_q_s[j][c] <= {qp[21:0], ge};
			end
		end
	end

	// exp2 approximation over three stages
	logic [15:0] e1_f [3];
	logic [15:0] e1_h [3];
	logic [31:0] e1_p [3];
	logic [15:0] e1_t_s [3];
	logic [15:0] e1_h_s [3];
	logic [6:0]  e1_n_s [3];
	logic        e1_fz_s [3];
	logic [30:0] e2_p [3];
	logic [14:0] e2_c_s [3];
	logic [15:0] e2_h_s [3];
	logic [6:0]  e2_n_s [3];
	logic        e2_fz_s [3];
	logic [16:0] e3_v [3];
	logic [16:0] e3_ye [3];
	logic [16:0] e3_yf [3];
	logic [16:0] e3_y_s [3];
	logic [24:0] o_prod [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1_f[i] = ed_q_s[ED_N-1][i][15:0];
			e1_h[i] = 16'(17'h10000 - {1'b0, e1_f[i]});
			e1_p[i] = 32'(e1_h[i]) * 32'(e1_f[i]);
			e2_p[i] = 31'(e1_t_s[i]) * 31'(ptmg_pkg::EXP_CORR);
			e3_v[i] = 17'(17'h10000 + {1'b0, e2_h_s[i]}) - {2'd0, e2_c_s[i]};
			if (e2_fz_s[i]) begin
				e3_ye[i] = (e2_n_s[i] > 7'd16) ? 17'd0 : (17'h10000 >> e2_n_s[i][4:0]);
			end else begin
				e3_ye[i] = (e2_n_s[i] > 7'd15) ? 17'd0
					: (e3_v[i] >> ({1'b0, e2_n_s[i][3:0]} + 5'd1));
			end
			if (gbyp || xv_s[XV_N-1][i][16]) begin
				e3_yf[i] = xv_s[XV_N-1][i];
			end else if (xv_s[XV_N-1][i] == 17'd0) begin
				e3_yf[i] = 17'd0;
			end else begin
				e3_yf[i] = e3_ye[i];
			end
			o_prod[i] = {e3_y_s[i], 8'd0} - {8'd0, e3_y_s[i]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e1_t_s[i]  <= e1_p[i][31:16];
			e1_h_s[i]  <= e1_h[i];
			e1_n_s[i]  <= ed_q_s[ED_N-1][i][22:16];
			e1_fz_s[i] <= (e1_f[i] == 16'd0);
			e2_c_s[i]  <= e2_p[i][30:16];
			e2_h_s[i]  <= e1_h_s[i];
			e2_n_s[i]  <= e1_n_s[i];
			e2_fz_s[i] <= e1_fz_s[i];
			e3_y_s[i]  <= e3_yf[i];
		end
		result.screen_x  <= crd_s[CRD_N-1][21:11];
		result.screen_y  <= crd_s[CRD_N-1][10:0];
		result.red_out   <= o_prod[0][23:16];
		result.green_out <= o_prod[1][23:16];
		result.blue_out  <= o_prod[2][23:16];
	end

`ifndef SYNTH
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request not answered after pipeline latency");

	a_col_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT (result.screen_x == $past(pixel.column, LAT)))
		else $error("screen_x does not match request column");

	a_oog_red: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && show_oog_q && pixel.red_raw > ptmg_pkg::ONE_FX)
		|-> ##LAT (result.green_out == 8'd0 && result.blue_out == 8'd0))
		else $error("out-of-gamut pixel not pure red");
`endif

endmodule

`default_nettype wire
